### sv/uwl_pkg.sv
// shared types, codes and constants of the uid watch list table
package uwl_pkg;

   localparam int unsigned SLOT_COUNT_DEF    = 128;
   localparam int unsigned UID_W             = 32;
   localparam int unsigned VER_W             = 4;
   localparam logic [UID_W-1:0] MIN_APP_UID_RESET = 32'd10000;
   localparam logic [VER_W-1:0] IP_VER_4     = 4'd4;
   localparam logic [VER_W-1:0] IP_VER_6     = 4'd6;
   localparam logic [UID_W-1:0] EMPTY_UID    = '0;
   localparam int unsigned REQ_DATA_W        = 40;
   localparam int unsigned RSP_DATA_W        = 40;

   typedef enum logic [1:0] {
      OP_ADD   = 2'd0,
      OP_DEL   = 2'd1,
      OP_CLEAR = 2'd2,
      OP_PKT   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      STS_DONE      = 3'd0,
      STS_PRESENT   = 3'd1,
      STS_FULL      = 3'd2,
      STS_NOT_FOUND = 3'd3,
      STS_IGNORED   = 3'd4,
      STS_NO_MATCH  = 3'd5,
      STS_MATCHED   = 3'd6
   } status_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_WIPE,
      ST_SCAN,
      ST_DRAIN,
      ST_COMMIT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic wipe;
      logic scan_rd;
      logic commit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic in_is_clear;
      logic in_needs_scan;
      logic cnt_last;
      logic out_free;
   } stat_type;

endpackage

### sv/uwl_ctrl.sv
// controller state machine of the uid watch list table
module uwl_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  uwl_pkg::stat_type  stat,
   output uwl_pkg::cmd_type   cmd
);
   import uwl_pkg::*;

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT: begin
            if (stat.cnt_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               if (stat.in_is_clear) begin
                  state_in = ST_WIPE;
               end else if (stat.in_needs_scan) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_COMMIT;
               end
            end
         end
         ST_WIPE: begin
            if (stat.cnt_last) state_in = ST_COMMIT;
         end
         ST_SCAN: begin
            if (stat.cnt_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (stat.out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_tready  = (state_ff == ST_IDLE);
      cmd.accept  = (state_ff == ST_IDLE) && req_tvalid;
      cmd.wipe    = (state_ff == ST_INIT) || (state_ff == ST_WIPE);
      cmd.scan_rd = (state_ff == ST_SCAN);
      cmd.commit  = (state_ff == ST_COMMIT) && stat.out_free;
   end

endmodule

### sv/uwl_dpath.sv
// datapath of the uid watch list table: slot memory, scan and result register
module uwl_dpath #(
   parameter int unsigned SLOT_COUNT = uwl_pkg::SLOT_COUNT_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [1:0]                       req_tuser,
   input  logic [uwl_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [2:0]                       rsp_tuser,
   output logic [uwl_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                             csr_we,
   input  logic [uwl_pkg::UID_W-1:0]        csr_wdata,
   input  uwl_pkg::cmd_type                 cmd,
   output uwl_pkg::stat_type                stat
);
   import uwl_pkg::*;

   localparam int unsigned IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

   logic [UID_W-1:0] mem [SLOT_COUNT];

   logic [UID_W-1:0] min_app_uid_ff;
   logic [IDX_W-1:0] cnt_ff, cnt_in;
   logic             rd_valid_ff;
   logic [IDX_W-1:0] rd_idx_ff;
   logic [UID_W-1:0] rd_data_ff;
   op_type           op_ff;
   logic [UID_W-1:0] uid_ff;
   logic             pass_ff;
   logic             match_ff, match_in;
   logic [IDX_W-1:0] match_idx_ff, match_idx_in;
   logic             empty_ff, empty_in;
   logic [IDX_W-1:0] empty_idx_ff, empty_idx_in;
   logic             rsp_valid_ff;
   status_type       rsp_status_ff, rsp_status_in;
   logic             rsp_report_ff, rsp_report_in;
   logic [UID_W-1:0] rsp_uid_ff, rsp_uid_in;

   op_type           in_op;
   logic [UID_W-1:0] in_uid;
   logic [VER_W-1:0] in_ver;
   logic             in_tcp;
   logic             in_full;
   logic             in_pass;

   logic             mem_we;
   logic [IDX_W-1:0] mem_wa;
   logic [UID_W-1:0] mem_wd;

   // unpack the request transfer
   assign in_op   = op_type'(req_tuser);
   assign in_uid  = req_tdata[UID_W-1:0];
   assign in_ver  = req_tdata[UID_W+VER_W-1:UID_W];
   assign in_tcp  = req_tdata[UID_W+VER_W];
   assign in_full = req_tdata[UID_W+VER_W+1];

   // packet filter
   assign in_pass = ((in_ver == IP_VER_4) || (in_ver == IP_VER_6)) && in_tcp && in_full
                    && (in_uid >= min_app_uid_ff);

   // status toward the controller
   always_comb begin
      stat.in_is_clear   = (in_op == OP_CLEAR);
      stat.in_needs_scan = (in_op == OP_ADD) || (in_op == OP_DEL)
                           || ((in_op == OP_PKT) && in_pass && (in_uid != EMPTY_UID));
      stat.cnt_last      = (cnt_ff == LAST_IDX);
      stat.out_free      = !rsp_valid_ff || rsp_tready;
   end

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         min_app_uid_ff <= MIN_APP_UID_RESET;
      end else if (csr_we) begin
         min_app_uid_ff <= csr_wdata;
      end
   end

   // slot counter for wipe and scan sweeps
   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.wipe || cmd.scan_rd) begin
         cnt_in = (cnt_ff == LAST_IDX) ? '0 : cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff      <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         cnt_ff      <= cnt_in;
         rd_valid_ff <= cmd.scan_rd;
      end
   end

   // latch the accepted item
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff   <= in_op;
         uid_ff  <= in_uid;
         pass_ff <= in_pass;
      end
   end

   // first match and first empty slot seen by the scan
   always_comb begin
      match_in     = match_ff;
      match_idx_in = match_idx_ff;
      empty_in     = empty_ff;
      empty_idx_in = empty_idx_ff;
      if (cmd.accept) begin
         match_in = 1'b0;
         empty_in = 1'b0;
      end else if (rd_valid_ff) begin
         if (!match_ff && (rd_data_ff == uid_ff)) begin
            match_in     = 1'b1;
            match_idx_in = rd_idx_ff;
         end
         if (!empty_ff && (rd_data_ff == EMPTY_UID)) begin
            empty_in     = 1'b1;
            empty_idx_in = rd_idx_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
         empty_ff <= 1'b0;
      end else begin
         match_ff <= match_in;
         empty_ff <= empty_in;
      end
      match_idx_ff <= match_idx_in;
      empty_idx_ff <= empty_idx_in;
   end

   // result and table update at commit, slot clearing during wipe
   always_comb begin
      rsp_status_in = STS_DONE;
      rsp_report_in = 1'b0;
      rsp_uid_in    = '0;
      mem_we        = 1'b0;
      mem_wa        = cnt_ff;
      mem_wd        = EMPTY_UID;
      if (cmd.wipe) begin
         mem_we = 1'b1;
      end else if (cmd.commit) begin
         case (op_ff)
            OP_ADD: begin
               if (match_ff) begin
                  rsp_status_in = STS_PRESENT;
               end else if (empty_ff) begin
                  mem_we = 1'b1;
                  mem_wa = empty_idx_ff;
                  mem_wd = uid_ff;
               end else begin
                  rsp_status_in = STS_FULL;
               end
            end
            OP_DEL: begin
               if (match_ff) begin
                  mem_we = 1'b1;
                  mem_wa = match_idx_ff;
               end else begin
                  rsp_status_in = STS_NOT_FOUND;
               end
            end
            OP_CLEAR: begin
               rsp_status_in = STS_DONE;
            end
            OP_PKT: begin
               if (!pass_ff) begin
                  rsp_status_in = STS_IGNORED;
               end else if ((uid_ff != EMPTY_UID) && match_ff) begin
                  mem_we        = 1'b1;
                  mem_wa        = match_idx_ff;
                  rsp_status_in = STS_MATCHED;
                  rsp_report_in = 1'b1;
                  rsp_uid_in    = uid_ff;
               end else begin
                  rsp_status_in = STS_NO_MATCH;
               end
            end
            default: begin
               rsp_status_in = STS_DONE;
            end
         endcase
      end
   end

   // slot memory, one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (cmd.scan_rd) begin
         rd_data_ff <= mem[cnt_ff];
         rd_idx_ff  <= cnt_ff;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_status_ff <= rsp_status_in;
         rsp_report_ff <= rsp_report_in;
         rsp_uid_ff    <= rsp_uid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - UID_W - 1){1'b0}}, rsp_uid_ff, rsp_report_ff};

endmodule

### sv/uid_watch_list_table.sv
// top level of the uid watch list table
// flow: add, delete and checked packets pass a scan of every slot, a drain state and commit;
//   clear-all passes a wipe of every slot and commit; ignored packets go straight to commit
// items: a new item is taken only in idle, once the last one has been committed to the
//   output register; the next item is taken while a result waits
// reset: synchronous, min_app_uid to 10000, then a clearing pass over every slot, no transfer in
module uid_watch_list_table #(
   parameter int unsigned SLOT_COUNT = uwl_pkg::SLOT_COUNT_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // tuser: opcode[1:0]
   input  logic [1:0]                      req_tuser,
   // tdata: uid[31:0], ip_version[35:32], is_tcp[36], has_full_socket[37], zero fill
   input  logic [uwl_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // tuser: status[2:0]
   output logic [2:0]                      rsp_tuser,
   // tdata: report[0], report_uid[32:1], zero fill
   output logic [uwl_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                            csr_we,
   input  logic [uwl_pkg::UID_W-1:0]       csr_wdata
);
   import uwl_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // sequencer
   uwl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // table and result path
   uwl_dpath #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .stat       (stat)
   );

endmodule
